FILE: hw/rtl/crc32fa_pkg.sv
//------------------------------------------------------------------------------
// crc32fa_pkg
// Shared types and constants of the CRC-32 frame append/check block.
//------------------------------------------------------------------------------
`default_nettype none

package crc32fa_pkg;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam crc_t CRC_INIT   = 32'hFFFF_FFFF;
  localparam crc_t POLY_RESET = 32'h04C1_1DB7;

  // configuration register indexes
  localparam logic CFG_CHECK_MODE = 1'b0;
  localparam logic CFG_GEN_POLY   = 1'b1;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_CHECK  = 1'b1;

endpackage : crc32fa_pkg

`default_nettype wire

FILE: hw/rtl/crc32fa_crc_step.sv
//------------------------------------------------------------------------------
// crc32fa_crc_step
// One byte of MSB-first CRC-32 update with a programmable generator.
//------------------------------------------------------------------------------
`default_nettype none

module crc32fa_crc_step (
  input  wire crc32fa_pkg::crc_t  crc_i,
  input  wire crc32fa_pkg::byte_t data_i,
  input  wire crc32fa_pkg::crc_t  poly_i,
  output crc32fa_pkg::crc_t       crc_o
);
  import crc32fa_pkg::*;

  always_comb begin
    crc_t c;
    c = {crc_i[CRC_W-1 -: BYTE_W] ^ data_i, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ poly_i;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    crc_o = {crc_i[CRC_W-BYTE_W-1:0], {BYTE_W{1'b0}}} ^ c;
  end

endmodule : crc32fa_crc_step

`default_nettype wire

FILE: hw/rtl/crc32_frame_append_check.sv
//------------------------------------------------------------------------------
// crc32_frame_append_check
// Byte-serial CRC-32 framer (append) and checker (check and strip).
//------------------------------------------------------------------------------
// Takes one frame byte per clock unless stalled by the output or the trailer,
// and runs an MSB-first CRC-32 (init all ones, no reflection, no final XOR,
// generator from cfg register 1). Append mode passes each byte through and
// follows the last byte with the four CRC bytes, MSB first; the input is held
// off while the trailer leaves the output register. Check mode keeps the last
// four bytes in a delay line and strips them, and flags a nonzero remainder on
// the final result (a status-only result when no payload byte goes with it).
// Path: input register, then CRC update into the output register.
`default_nettype none

module crc32_frame_append_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // frame_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic [1:0]       out_tuser,  // [0] byte_present, [1] crc_error
  output logic             out_tlast,  // out_end
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import crc32fa_pkg::*;

  logic  mode_r;
  crc_t  poly_r;

  logic  in_valid_r;
  byte_t in_byte_r;
  logic  in_last_r;

  crc_t  crc_r, crc_nxt, crc_upd;
  byte_t tail_r [4];
  byte_t tail_nxt [4];
  logic [2:0] tail_cnt_r, tail_cnt_nxt;

  crc_t  trail_r, trail_nxt;
  logic [2:0] trail_cnt_r, trail_cnt_nxt;

  logic  out_valid_r, out_valid_nxt;
  byte_t out_byte_r, out_byte_nxt;
  logic  out_present_r, out_present_nxt;
  logic  out_end_r, out_end_nxt;
  logic  out_err_r, out_err_nxt;

  logic  out_load;
  logic  consume;

  assign out_load  = !out_valid_r || out_tready;
  assign consume   = out_load && (trail_cnt_r == 3'd0) && in_valid_r;
  assign in_tready = !in_valid_r || consume;

  crc32fa_crc_step u_crc_step (
    .crc_i  (crc_r),
    .data_i (in_byte_r),
    .poly_i (poly_r),
    .crc_o  (crc_upd)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_APPEND;
      poly_r <= POLY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHECK_MODE: mode_r <= cfg_wdata[0];
        CFG_GEN_POLY:   poly_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // CRC update, delay line and result selection
  always_comb begin
    logic  emit;
    byte_t old;
    crc_nxt         = crc_r;
    tail_nxt        = tail_r;
    tail_cnt_nxt    = tail_cnt_r;
    trail_nxt       = trail_r;
    trail_cnt_nxt   = trail_cnt_r;
    out_valid_nxt   = out_valid_r;
    out_byte_nxt    = out_byte_r;
    out_present_nxt = out_present_r;
    out_end_nxt     = out_end_r;
    out_err_nxt     = out_err_r;
    emit            = tail_cnt_r[2];
    old             = tail_r[0];

    if (out_load) begin
      out_valid_nxt = 1'b0;
      if (trail_cnt_r != 3'd0) begin
        out_valid_nxt   = 1'b1;
        out_byte_nxt    = trail_r[CRC_W-1 -: BYTE_W];
        out_present_nxt = 1'b1;
        out_end_nxt     = (trail_cnt_r == 3'd1);
        out_err_nxt     = 1'b0;
        trail_nxt       = {trail_r[CRC_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
        trail_cnt_nxt   = trail_cnt_r - 3'd1;
      end else if (in_valid_r) begin
        crc_nxt = crc_upd;
        if (mode_r == MODE_APPEND) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = in_byte_r;
          out_present_nxt = 1'b1;
          out_end_nxt     = 1'b0;
          out_err_nxt     = 1'b0;
          if (in_last_r) begin
            trail_nxt     = crc_upd;
            trail_cnt_nxt = 3'd4;
          end
        end else begin
          if (emit) begin
            tail_nxt[0] = tail_r[1];
            tail_nxt[1] = tail_r[2];
            tail_nxt[2] = tail_r[3];
            tail_nxt[3] = in_byte_r;
          end else begin
            tail_nxt[tail_cnt_r[1:0]] = in_byte_r;
            tail_cnt_nxt = tail_cnt_r + 3'd1;
          end
          out_valid_nxt   = emit || in_last_r;
          out_byte_nxt    = emit ? old : '0;
          out_present_nxt = emit;
          out_end_nxt     = in_last_r;
          out_err_nxt     = in_last_r && (crc_upd != '0);
        end
        if (in_last_r) begin
          crc_nxt      = CRC_INIT;
          tail_cnt_nxt = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      tail_cnt_r  <= 3'd0;
      trail_cnt_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      tail_cnt_r  <= tail_cnt_nxt;
      trail_cnt_r <= trail_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r        <= tail_nxt;
    trail_r       <= trail_nxt;
    out_byte_r    <= out_byte_nxt;
    out_present_r <= out_present_nxt;
    out_end_r     <= out_end_nxt;
    out_err_r     <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_err_r, out_present_r};
  assign out_tlast  = out_end_r;

endmodule : crc32_frame_append_check

`default_nettype wire
